// ===== src/tes_pkg.sv =====
// shared types, widths and codes for the touch event scaler
package tes_pkg;

    // converter and screen coordinate widths
    localparam int RAW_BITS   = 12;
    localparam int COORD_BITS = 12;

    // configuration register widths
    localparam int SIZE_W     = 13;
    localparam int INTERVAL_W = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // largest screen size an axis can map onto
    localparam int unsigned MAX_SIZE = 1 << COORD_BITS;

    // divider sizing: numerator is |v - start| * (size - 1)
    localparam int PROD_W    = RAW_BITS + COORD_BITS;
    localparam int REM_W     = RAW_BITS + 1;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // reset values of the configuration registers
    localparam logic [SIZE_W-1:0]     RST_WIDTH    = SIZE_W'(320);
    localparam logic [SIZE_W-1:0]     RST_HEIGHT   = SIZE_W'(240);
    localparam logic [RAW_BITS-1:0]   RST_START    = RAW_BITS'(200);
    localparam logic [RAW_BITS-1:0]   RST_END      = RAW_BITS'(3800);
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = INTERVAL_W'(30);

    // event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_MOVE = 2'd2,
        EV_UP   = 2'd3
    } t_event;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_HEIGHT   = 3'd2,
        REG_X_START  = 3'd3,
        REG_X_END    = 3'd4,
        REG_Y_START  = 3'd5,
        REG_Y_END    = 3'd6,
        REG_INTERVAL = 3'd7
    } t_cfg_idx;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic div_step;
        logic finish;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic map_needed;
        logic out_free;
    } t_status;

endpackage

// ===== src/tes_ctrl.sv =====
// controller state machine sequencing one request through the datapath
module tes_ctrl
    import tes_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state register and divide step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (i_status.map_needed) begin
                    o_cmd.mul = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // new requests only between items
    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== src/tes_datapath.sv =====
// configuration, touch state, axis mapping and divider datapath
module tes_datapath
    import tes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_pressed,
    input  logic [RAW_BITS-1:0]   i_raw_x,
    input  logic [RAW_BITS-1:0]   i_raw_y,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [1:0]            o_event_kind,
    output logic [COORD_BITS-1:0] o_screen_x,
    output logic [COORD_BITS-1:0] o_screen_y
);

    typedef struct packed {
        logic [RAW_BITS-1:0]   diff;
        logic [RAW_BITS-1:0]   den;
        logic [COORD_BITS-1:0] top;
    } t_axis;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] quo;
    } t_div;

    // clamp into the window, take distances from start and the output top
    function automatic t_axis axis_prep(
        input logic [RAW_BITS-1:0] value,
        input logic [RAW_BITS-1:0] start,
        input logic [RAW_BITS-1:0] stop,
        input logic [SIZE_W-1:0]   size
    );
        logic [RAW_BITS-1:0]   lo;
        logic [RAW_BITS-1:0]   hi;
        logic [RAW_BITS-1:0]   v;
        logic [COORD_BITS:0]   sat;
        t_axis                 a;
        lo = (start < stop) ? start : stop;
        hi = (start < stop) ? stop : start;
        v  = value;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        if (size == '0) begin
            sat = (COORD_BITS+1)'(1);
        end else if (32'(size) > MAX_SIZE) begin
            sat = (COORD_BITS+1)'(MAX_SIZE);
        end else begin
            sat = (COORD_BITS+1)'(size);
        end
        a.diff = (v >= start) ? (v - start) : (start - v);
        a.den  = (stop >= start) ? (stop - start) : (start - stop);
        a.top  = COORD_BITS'(sat - 1'b1);
        return a;
    endfunction

    // one restoring division step
    function automatic t_div div_step(
        input t_div                d,
        input logic [RAW_BITS-1:0] den
    );
        logic [REM_W-1:0] sh;
        t_div             r;
        sh = {d.rem[REM_W-2:0], d.quo[PROD_W-1]};
        if (sh >= {1'b0, den}) begin
            r.rem = sh - {1'b0, den};
            r.quo = {d.quo[PROD_W-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.quo = {d.quo[PROD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // configuration registers
    logic                  r_enable;
    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;
    logic [RAW_BITS-1:0]   r_x_start;
    logic [RAW_BITS-1:0]   r_x_end;
    logic [RAW_BITS-1:0]   r_y_start;
    logic [RAW_BITS-1:0]   r_y_end;
    logic [INTERVAL_W-1:0] r_interval;

    // touch state
    logic [TIME_W-1:0]     r_last_time;
    logic                  r_was_pressed;
    logic [COORD_BITS-1:0] r_held_x;
    logic [COORD_BITS-1:0] r_held_y;

    // captured request
    logic [TIME_W-1:0]     r_now;
    logic                  r_pressed;
    logic [RAW_BITS-1:0]   r_raw_x;
    logic [RAW_BITS-1:0]   r_raw_y;

    // evaluation and divider registers
    logic                  r_handled;
    t_axis                 r_ax;
    t_axis                 r_ay;
    t_div                  r_dx;
    t_div                  r_dy;

    // output register
    logic                  r_valid;
    t_event                r_kind;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;

    logic [TIME_W-1:0]     elapsed;
    logic [COORD_BITS-1:0] map_x;
    logic [COORD_BITS-1:0] map_y;
    t_event                n_kind;
    logic [COORD_BITS-1:0] n_out_x;
    logic [COORD_BITS-1:0] n_out_y;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_x_start  <= RST_START;
            r_x_end    <= RST_END;
            r_y_start  <= RST_START;
            r_y_end    <= RST_END;
            r_interval <= RST_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
                REG_X_START:  r_x_start  <= i_cfg_data[RAW_BITS-1:0];
                REG_X_END:    r_x_end    <= i_cfg_data[RAW_BITS-1:0];
                REG_Y_START:  r_y_start  <= i_cfg_data[RAW_BITS-1:0];
                REG_Y_END:    r_y_end    <= i_cfg_data[RAW_BITS-1:0];
                REG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now     <= i_now_ms;
            r_pressed <= i_pressed;
            r_raw_x   <= i_raw_x;
            r_raw_y   <= i_raw_y;
        end
    end

    // interval check on the wrapped elapsed time
    assign elapsed = r_now - r_last_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handled <= 1'b0;
        end else if (i_cmd.eval) begin
            r_handled <= r_enable && (elapsed >= TIME_W'(r_interval));
        end
    end

    // window clamp and spans per axis
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_ax <= axis_prep(r_raw_x, r_x_start, r_x_end, r_width);
            r_ay <= axis_prep(r_raw_y, r_y_start, r_y_end, r_height);
        end
    end

    // multiply then divide, one quotient bit per cycle on each axis
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dx.rem <= '0;
            r_dx.quo <= PROD_W'(r_ax.diff) * PROD_W'(r_ax.top);
            r_dy.rem <= '0;
            r_dy.quo <= PROD_W'(r_ay.diff) * PROD_W'(r_ay.top);
        end else if (i_cmd.div_step) begin
            r_dx <= div_step(r_dx, r_ax.den);
            r_dy <= div_step(r_dy, r_ay.den);
        end
    end

    // a zero span maps to zero; the quotient never exceeds the top
    assign map_x = (r_ax.den == '0) ? '0 : r_dx.quo[COORD_BITS-1:0];
    assign map_y = (r_ay.den == '0) ? '0 : r_dy.quo[COORD_BITS-1:0];

    // event decision
    always_comb begin
        n_kind  = EV_NONE;
        n_out_x = '0;
        n_out_y = '0;
        if (r_handled) begin
            if (r_pressed) begin
                n_kind  = r_was_pressed ? EV_MOVE : EV_DOWN;
                n_out_x = map_x;
                n_out_y = map_y;
            end else if (r_was_pressed) begin
                n_kind  = EV_UP;
                n_out_x = r_held_x;
                n_out_y = r_held_y;
            end
        end
    end

    // touch state update when a sample is handled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_was_pressed <= 1'b0;
            r_held_x      <= '0;
            r_held_y      <= '0;
        end else if (i_cmd.finish && r_handled) begin
            r_last_time   <= r_now;
            r_was_pressed <= r_pressed;
            if (r_pressed) begin
                r_held_x <= map_x;
                r_held_y <= map_y;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_kind  <= n_kind;
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    // status back to the controller
    assign o_status.map_needed = r_handled && r_pressed;
    assign o_status.out_free   = !r_valid || !i_stall;

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_screen_x   = r_out_x;
    assign o_screen_y   = r_out_y;

endmodule

// ===== src/touch_event_scaler_unit.sv =====
// touch event scaler top level: controller and datapath
//
// input channel: i_valid/o_stall carry a request of timestamp, pressed flag
// and raw x/y; a request is taken when i_valid is high and o_stall is low.
// output channel: o_valid/i_stall carry event kind and screen x/y from an
// output register; a result is taken when o_valid is high and i_stall is low.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the
// clock edge; write only while no request is in flight.
// a sample that is mapped (enabled, interval elapsed, panel pressed) passes
// from acceptance through the evaluate state, the multiply state, the
// bit-serial restoring dividers (one per axis, RAW_BITS + COORD_BITS steps)
// and the result state before the next request is taken; its result shows
// on o_valid from the output register. others skip multiply and divide.
// the next request is taken while a result still waits in the output
// register; a stalled receiver only holds the block in its result state.
// reset (synchronous, active low) loads the default calibration, disables
// the block and clears the touch state and the output valid.
module touch_event_scaler_unit
    import tes_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_pressed,
    input  logic [RAW_BITS-1:0]   i_raw_x,
    input  logic [RAW_BITS-1:0]   i_raw_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_event_kind,
    output logic [COORD_BITS-1:0] o_screen_x,
    output logic [COORD_BITS-1:0] o_screen_y
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    tes_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // datapath
    tes_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_now_ms     (i_now_ms),
        .i_pressed    (i_pressed),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the touch event scaler: calibration phases, touch strokes and event checks
module tb_top;
    import tes_pkg::*;

    localparam int TARGET_SENT    = 1350;
    localparam int GAP_MAX        = 17;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TAIL_CYCLES    = 40;

    // one screen event as the block reports it
    typedef struct packed {
        t_event                kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_touch_event;

    // one full calibration setting
    typedef struct packed {
        logic                  en;
        logic [SIZE_W-1:0]     w;
        logic [SIZE_W-1:0]     h;
        logic [RAW_BITS-1:0]   xs;
        logic [RAW_BITS-1:0]   xe;
        logic [RAW_BITS-1:0]   ys;
        logic [RAW_BITS-1:0]   ye;
        logic [INTERVAL_W-1:0] ivl;
    } t_calib;

    // touch event predictor and queue of events still owed by the block
    class touch_event_scoreboard;
        t_calib                cal;
        logic [TIME_W-1:0]     last_time;
        logic                  touching;
        logic [COORD_BITS-1:0] held_x;
        logic [COORD_BITS-1:0] held_y;
        t_touch_event          pending_events[$];
        int                    errors;
        int                    n_checked;
        int                    kind_count[4];

        function new();
            cal.en    = 1'b0;
            cal.w     = RST_WIDTH;
            cal.h     = RST_HEIGHT;
            cal.xs    = RST_START;
            cal.xe    = RST_END;
            cal.ys    = RST_START;
            cal.ye    = RST_END;
            cal.ivl   = RST_INTERVAL;
            last_time = '0;
            touching  = 1'b0;
            held_x    = '0;
            held_y    = '0;
            errors    = 0;
            n_checked = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        // register write as the block latches it
        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE:   cal.en  = data[0];
                REG_WIDTH:    cal.w   = data[SIZE_W-1:0];
                REG_HEIGHT:   cal.h   = data[SIZE_W-1:0];
                REG_X_START:  cal.xs  = data[RAW_BITS-1:0];
                REG_X_END:    cal.xe  = data[RAW_BITS-1:0];
                REG_Y_START:  cal.ys  = data[RAW_BITS-1:0];
                REG_Y_END:    cal.ye  = data[RAW_BITS-1:0];
                REG_INTERVAL: cal.ivl = data[INTERVAL_W-1:0];
                default: ;
            endcase
        endfunction

        // clamp into the window, scale onto 0..size-1 truncating toward zero, clamp again
        function logic [COORD_BITS-1:0] scale_axis(logic [RAW_BITS-1:0] raw,
                                                   logic [RAW_BITS-1:0] start,
                                                   logic [RAW_BITS-1:0] stop,
                                                   logic [SIZE_W-1:0] size);
            longint s, e, lo, hi, v, top, span, r, sz;
            s  = start;
            e  = stop;
            v  = raw;
            sz = size;
            if (sz == 0) sz = 1;
            if (sz > MAX_SIZE) sz = MAX_SIZE;
            top = sz - 1;
            lo  = (s < e) ? s : e;
            hi  = (s < e) ? e : s;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            span = e - s;
            if (span == 0) r = 0;
            else r = ((v - s) * top) / span;
            if (r < 0) r = 0;
            if (r > top) r = top;
            return r[COORD_BITS-1:0];
        endfunction

        // predict the event for an accepted request; returns 1 when the sample is acted on
        function bit log_sample(logic [TIME_W-1:0] now, logic pressed,
                                logic [RAW_BITS-1:0] rx, logic [RAW_BITS-1:0] ry);
            t_touch_event      ev;
            logic [TIME_W-1:0] elapsed;
            bit                handled;
            ev.kind = EV_NONE;
            ev.x    = '0;
            ev.y    = '0;
            elapsed = now - last_time;
            handled = cal.en && (elapsed >= cal.ivl);
            if (handled) begin
                last_time = now;
                if (pressed) begin
                    held_x  = scale_axis(rx, cal.xs, cal.xe, cal.w);
                    held_y  = scale_axis(ry, cal.ys, cal.ye, cal.h);
                    ev.kind = touching ? EV_MOVE : EV_DOWN;
                    ev.x    = held_x;
                    ev.y    = held_y;
                end else if (touching) begin
                    ev.kind = EV_UP;
                    ev.x    = held_x;
                    ev.y    = held_y;
                end
                touching = pressed;
            end
            kind_count[int'(ev.kind)]++;
            pending_events.push_back(ev);
            return handled;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("tb: mismatch at %0t: %s", $time, msg);
        endtask

        // compare a delivered event with the oldest one owed
        task match_event(logic [1:0] kind, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            t_touch_event exp_ev;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d x %0d y %0d", kind, x, y));
                return;
            end
            exp_ev = pending_events.pop_front();
            n_checked++;
            if (kind !== exp_ev.kind)
                report($sformatf("event %0d kind %0d, want %0d", n_checked, kind, exp_ev.kind));
            if (x !== exp_ev.x)
                report($sformatf("event %0d x %0d, want %0d", n_checked, x, exp_ev.x));
            if (y !== exp_ev.y)
                report($sformatf("event %0d y %0d, want %0d", n_checked, y, exp_ev.y));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [TIME_W-1:0]     i_now_ms    = '0;
    logic                  i_pressed   = 1'b0;
    logic [RAW_BITS-1:0]   i_raw_x     = '0;
    logic [RAW_BITS-1:0]   i_raw_y     = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [1:0]            o_event_kind;
    logic [COORD_BITS-1:0] o_screen_x;
    logic [COORD_BITS-1:0] o_screen_y;

    touch_event_scoreboard sb;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int sent_count    = 0;
    int handled_count = 0;
    int phase_count   = 0;
    int idle_cycles   = 0;

    touch_event_scaler_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_ms     (i_now_ms),
        .i_pressed    (i_pressed),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side: random stall before each event, then take and check it
    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            sb.match_event(o_event_kind, o_screen_x, o_screen_y);
        end
    end

    // one register write; the caller drops the write enable after its last write
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // write all registers, junk in the unused upper data bits
    task automatic load_calibration(input t_calib c);
        write_reg(REG_ENABLE,   CFG_DATA_W'({$urandom, c.en}));
        write_reg(REG_WIDTH,    CFG_DATA_W'({$urandom, c.w}));
        write_reg(REG_HEIGHT,   CFG_DATA_W'({$urandom, c.h}));
        write_reg(REG_X_START,  CFG_DATA_W'({$urandom, c.xs}));
        write_reg(REG_X_END,    CFG_DATA_W'({$urandom, c.xe}));
        write_reg(REG_Y_START,  CFG_DATA_W'({$urandom, c.ys}));
        write_reg(REG_Y_END,    CFG_DATA_W'({$urandom, c.ye}));
        write_reg(REG_INTERVAL, c.ivl);
        i_cfg_we <= 1'b0;
    endtask

    // issue one sample request after a random gap and wait until it is taken
    task automatic send_sample(input logic [TIME_W-1:0] now, input logic pressed,
                               input logic [RAW_BITS-1:0] rx, input logic [RAW_BITS-1:0] ry);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_now_ms  <= now;
        i_pressed <= pressed;
        i_raw_x   <= rx;
        i_raw_y   <= ry;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (sb.log_sample(now, pressed, rx, ry)) handled_count++;
        sent_count++;
    endtask

    // hold requests back until every owed event has been delivered
    task automatic wait_for_events();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_calib make_calib(logic en, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                                          logic [RAW_BITS-1:0] xs, logic [RAW_BITS-1:0] xe,
                                          logic [RAW_BITS-1:0] ys, logic [RAW_BITS-1:0] ye,
                                          logic [INTERVAL_W-1:0] ivl);
        t_calib c;
        c.en  = en;
        c.w   = w;
        c.h   = h;
        c.xs  = xs;
        c.xe  = xe;
        c.ys  = ys;
        c.ye  = ye;
        c.ivl = ivl;
        return c;
    endfunction

    // screen size, including zero and sizes past the coordinate range
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(2);
            3:       return SIZE_W'(MAX_SIZE);
            4:       return '1;
            5:       return SIZE_W'($urandom_range(MAX_SIZE + 1, 8191));
            default: return SIZE_W'($urandom_range(1, MAX_SIZE));
        endcase
    endfunction

    // calibration window: normal, equal bounds, mirrored or full range
    function automatic void pick_window(output logic [RAW_BITS-1:0] s,
                                        output logic [RAW_BITS-1:0] e);
        case ($urandom_range(0, 7))
            0: begin
                s = RAW_BITS'($urandom_range(0, 4095));
                e = s;
            end
            1: begin
                e = RAW_BITS'($urandom_range(0, 2000));
                s = RAW_BITS'($urandom_range(2001, 4095));
            end
            2: begin
                s = '0;
                e = '1;
            end
            3: begin
                s = '1;
                e = '0;
            end
            4: begin
                s = RST_START;
                e = RST_END;
            end
            default: begin
                s = RAW_BITS'($urandom_range(0, 2000));
                e = RAW_BITS'($urandom_range(2001, 4095));
            end
        endcase
    endfunction

    function automatic t_calib pick_calibration();
        t_calib c;
        c.en = ($urandom_range(0, 7) != 0);
        c.w  = pick_size();
        c.h  = pick_size();
        pick_window(c.xs, c.xe);
        pick_window(c.ys, c.ye);
        case ($urandom_range(0, 7))
            0:       c.ivl = '0;
            1:       c.ivl = '1;
            2:       c.ivl = INTERVAL_W'(1);
            3:       c.ivl = INTERVAL_W'($urandom_range(0, 65535));
            default: c.ivl = INTERVAL_W'($urandom_range(2, 100));
        endcase
        return c;
    endfunction

    // time advance: mostly past the interval, sometimes early, sometimes a far jump
    function automatic logic [TIME_W-1:0] time_step(logic [INTERVAL_W-1:0] ivl);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return TIME_W'(ivl) + TIME_W'($urandom_range(0, 40));
            6, 7:             return TIME_W'($urandom_range(0, ivl));
            8:                return TIME_W'($urandom);
            default:          return '0;
        endcase
    endfunction

    // finger drift around the previous reading
    function automatic logic [RAW_BITS-1:0] wander(logic [RAW_BITS-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 96)) - 48;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[RAW_BITS-1:0];
    endfunction

    initial begin : stimulus
        t_calib              cal;
        logic [TIME_W-1:0]   now;
        logic                pressed;
        logic [RAW_BITS-1:0] rx;
        logic [RAW_BITS-1:0] ry;
        logic [RAW_BITS-1:0] base_x;
        logic [RAW_BITS-1:0] base_y;
        int                  quota;
        int                  phase_sent;
        int                  phase_start;
        int                  stroke_left;
        bit                  stroke_down;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // still disabled after reset: every sample gives none
        send_sample(32'd100, 1'b1, 12'd2000, 12'd2000);
        send_sample(32'd200, 1'b0, 12'd0, 12'd0);

        // default calibration, enabled: clamping, interval gating, down/move/up, time wrap
        wait_for_events();
        load_calibration(make_calib(1'b1, RST_WIDTH, RST_HEIGHT, RST_START, RST_END,
                                    RST_START, RST_END, RST_INTERVAL));
        send_sample(32'd100, 1'b1, 12'd0, 12'd0);
        send_sample(32'd130, 1'b1, 12'd4095, 12'd4095);
        send_sample(32'd140, 1'b1, 12'd2000, 12'd2000);
        send_sample(32'd200, 1'b0, 12'd1000, 12'd1000);
        send_sample(32'd240, 1'b0, 12'd1000, 12'd1000);
        send_sample(32'd250, 1'b1, 12'd1000, 12'd1000);
        send_sample(32'd270, 1'b1, 12'd200, 12'd3800);
        send_sample(32'd300, 1'b1, 12'd3800, 12'd200);
        send_sample(32'hFFFF_FFF0, 1'b1, 12'd2048, 12'd1000);
        send_sample(32'h0000_0005, 1'b1, 12'd100, 12'd100);
        send_sample(32'h0000_000E, 1'b0, 12'd100, 12'd100);

        // zero width, oversized height, equal x bounds, mirrored y, no interval
        wait_for_events();
        load_calibration(make_calib(1'b1, '0, '1, 12'd1000, 12'd1000, 12'd3800, 12'd200, '0));
        send_sample(32'h0000_000E, 1'b1, 12'd0, 12'd0);
        send_sample(32'h0000_000E, 1'b1, 12'd4095, 12'd4095);
        send_sample(32'h0000_000E, 1'b1, 12'd2000, 12'd2000);
        send_sample(32'h0000_000E, 1'b0, 12'd2000, 12'd2000);

        // full-size width, height of one, full windows, longest interval
        wait_for_events();
        load_calibration(make_calib(1'b1, SIZE_W'(MAX_SIZE), SIZE_W'(1), '0, '1, '1, '0, '1));
        send_sample(32'h0001_000D, 1'b1, 12'd4095, 12'd0);
        send_sample(32'h0002_000B, 1'b1, 12'd0, 12'd4095);
        send_sample(32'h0002_000C, 1'b0, 12'd0, 12'd0);

        // random calibration phases with touch strokes and some noise
        now         = 32'h0002_000C;
        stroke_left = 0;
        stroke_down = 1'b0;
        base_x      = '0;
        base_y      = '0;
        while (sent_count < TARGET_SENT) begin
            wait_for_events();
            cal = pick_calibration();
            load_calibration(cal);
            tx_calm     = ($urandom_range(0, 3) == 0);
            rx_calm     = ($urandom_range(0, 3) == 0);
            quota       = $urandom_range(60, 140);
            phase_sent  = 0;
            phase_start = handled_count;
            while ((handled_count - phase_start) < quota && phase_sent < 3 * quota &&
                   (cal.en || phase_sent < 25) && sent_count < TARGET_SENT) begin
                // mid-phase hold-off until the block has caught up
                if (phase_sent == quota / 2) wait_for_events();
                if (stroke_left == 0) begin
                    stroke_down = !stroke_down;
                    stroke_left = stroke_down ? $urandom_range(1, 12) : $urandom_range(1, 4);
                    base_x      = RAW_BITS'($urandom_range(0, 4095));
                    base_y      = RAW_BITS'($urandom_range(0, 4095));
                end
                stroke_left--;
                if ($urandom_range(0, 9) == 0) begin
                    pressed = $urandom_range(0, 1);
                    rx      = RAW_BITS'($urandom);
                    ry      = RAW_BITS'($urandom);
                end else begin
                    pressed = stroke_down;
                    rx      = wander(base_x);
                    ry      = wander(base_y);
                    base_x  = rx;
                    base_y  = ry;
                end
                now = now + time_step(cal.ivl);
                send_sample(now, pressed, rx, ry);
                phase_sent++;
            end
            phase_count++;
        end

        // drain and let the block settle
        wait_for_events();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d sample requests, %0d acted on, %0d random calibration settings",
                 sent_count, handled_count, phase_count);
        $display("tb: events checked %0d (none %0d, down %0d, move %0d, up %0d), %0d mismatches",
                 sb.n_checked, sb.kind_count[int'(EV_NONE)], sb.kind_count[int'(EV_DOWN)],
                 sb.kind_count[int'(EV_MOVE)], sb.kind_count[int'(EV_UP)], sb.errors);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
